>>> design/tspl_pkg.sv
// Shared constants, types and the tanh table for the three-pole saturating lowpass.
`default_nettype none

package tspl_pkg;

  localparam int SIG_W            = 24;
  localparam int SAMPLE_FRAC_BITS = 16;
  localparam int COEF_FRAC        = 16;

  localparam int TANH_TABLE_DEPTH = 256;
  localparam int TANH_AW          = $clog2(TANH_TABLE_DEPTH);
  localparam int TANH_W           = 18;
  localparam int TANH_SPAN_LOG2   = 3;
  localparam int TANH_SH          = SAMPLE_FRAC_BITS + TANH_SPAN_LOG2;

  localparam logic [TANH_W-1:0] TANH_ONE = TANH_W'(1 << SAMPLE_FRAC_BITS);

  localparam int POLE_W = 18;
  localparam int HALF_W = 18;
  localparam int FBG_W  = 21;
  localparam int DRV_W  = 23;
  localparam int OUTG_W = 19;

  localparam int CFG_W     = 23;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_POLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FBG  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRV  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTG = 3'd4;

  localparam logic signed [POLE_W-1:0] POLE_RST = -18'sd65431;
  localparam logic [HALF_W-1:0]        HALF_RST = 18'd52;
  localparam logic [FBG_W-1:0]         FBG_RST  = 21'd0;
  localparam logic [DRV_W-1:0]         DRV_RST  = 23'd65536;
  localparam logic [OUTG_W-1:0]        OUTG_RST = 19'd196608;

  // Operand selection of the shared multiplier
  typedef logic [2:0] mul_sel_t;
  localparam mul_sel_t MUL_FB    = 3'd0;
  localparam mul_sel_t MUL_TANH  = 3'd1;
  localparam mul_sel_t MUL_STAGE = 3'd2;
  localparam mul_sel_t MUL_DRIVE = 3'd3;
  localparam mul_sel_t MUL_OUT   = 3'd4;

  typedef struct packed {
    logic       ld_x;
    logic       mul_en;
    mul_sel_t   mul_sel;
    logic       ld_targ;
    logic       ld_abs;
    logic       ld_lut;
    logic       ld_t;
    logic       ld_f;
    logic       ld_sum;
    logic       ld_acc;
    logic       ld_stage;
    logic [1:0] stage;
    logic       ld_out;
  } tspl_cmd_t;

  typedef logic [TANH_TABLE_DEPTH-1:0][TANH_W-1:0] tanh_tab_t;

  function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [32:0] v);
    if (v > 33'sd8388607) begin
      return 24'h7FFFFF;
    end else if (v < -33'sd8388608) begin
      return 24'h800000;
    end
    return v[SIG_W-1:0];
  endfunction

  // Restoring division, only evaluated while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    int          i;
    q   = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(8k/depth): e = r^k with r a Taylor series for exp(-16/depth) in Q.32
  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t   tab;
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    int          n;
    int          k;
    h    = (64'd16 << 32) / 64'(TANH_TABLE_DEPTH);
    term = 64'd1 << 32;
    r    = 64'd1 << 32;
    e    = 64'd1 << 32;
    for (n = 1; n < 25; n++) begin
      term = udiv64((term * h + 64'h8000_0000) >> 32, 64'(n));
      if (n[0]) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    for (k = 0; k < TANH_TABLE_DEPTH; k++) begin
      den = (64'd1 << 32) + e;
      num = ((64'd1 << 32) - e) << SAMPLE_FRAC_BITS;
      tab[k[TANH_AW-1:0]] = TANH_W'(udiv64(num + (den >> 1), den));
      e = (e * r + 64'h8000_0000) >> 32;
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

`default_nettype wire

>>> design/tspl_dp.sv
// Datapath: coefficient registers, filter state, shared multiplier pair, tanh lookup.
`default_nettype none

module tspl_dp import tspl_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]            cfg_data,
  input  wire logic signed [SIG_W-1:0]     in_sample_in,
  input  wire tspl_cmd_t                   cmd,
  output logic signed [SIG_W-1:0]          out_sample_out
);

  localparam int MULX_W = SIG_W + 1;
  localparam int MULY_W = SIG_W;
  localparam int PROD_W = MULX_W + MULY_W;
  localparam int PRDB_W = POLE_W + SIG_W;
  localparam int ACC_W  = 45;
  localparam int TARG_W = PROD_W - COEF_FRAC;
  localparam logic [PROD_W-1:0] RND_C  = PROD_W'(1) << (COEF_FRAC - 1);
  localparam logic [PROD_W-1:0] RND_T  = PROD_W'(1) << (TANH_SH - 1);
  localparam logic [ACC_W-1:0]  RND_A  = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic [TARG_W-1:0] T_LIM  = TARG_W'(8) << SAMPLE_FRAC_BITS;

  logic signed [POLE_W-1:0] pole_r;
  logic [HALF_W-1:0]        half_r;
  logic [FBG_W-1:0]         fbg_r;
  logic [DRV_W-1:0]         drv_r;
  logic [OUTG_W-1:0]        outg_r;

  logic signed [SIG_W-1:0]  fed_r;
  logic signed [SIG_W-1:0]  st1_r;
  logic signed [SIG_W-1:0]  st2_r;
  logic signed [SIG_W-1:0]  st3_r;

  logic signed [SIG_W-1:0]  x_r;
  logic signed [SIG_W-1:0]  cur_r;
  logic signed [MULX_W-1:0] sum_r;
  logic signed [PROD_W-1:0] prod_a_r;
  logic signed [PRDB_W-1:0] prod_b_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [TARG_W-1:0] targ_r;
  logic [TANH_SH-1:0]       tabs_r;
  logic                     tneg_r;
  logic                     tbig_r;
  logic [TANH_W-1:0]        lo_r;
  logic signed [TANH_W:0]   diff_r;
  logic [TANH_SH-1:0]       frac_r;
  logic signed [TANH_W-1:0] t_r;
  logic signed [SIG_W-1:0]  out_r;

  logic signed [MULX_W-1:0] opx;
  logic signed [MULY_W-1:0] opy;
  logic signed [SIG_W-1:0]  xp;
  logic signed [SIG_W-1:0]  yp;
  logic signed [PROD_W-1:0] prod_a_nxt;
  logic signed [PRDB_W-1:0] prod_b_nxt;
  logic [PROD_W-1:0]        rnd_c;
  logic [PROD_W-1:0]        rnd_t;
  logic [ACC_W-1:0]         rnd_a;
  logic [TARG_W-1:0]        tmag;
  logic [TANH_AW-1:0]       idx;
  logic [TANH_W-1:0]        hi;
  logic [TANH_W:0]          v_sum;
  logic [TANH_W-1:0]        tpos;
  logic signed [TANH_W-1:0] t_nxt;
  logic [MULX_W-1:0]        fdiff;
  logic signed [SIG_W-1:0]  f_nxt;
  logic signed [SIG_W-1:0]  y_nxt;
  logic signed [SIG_W-1:0]  out_nxt;
  logic signed [ACC_W-1:0]  acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_r <= POLE_RST;
      half_r <= HALF_RST;
      fbg_r  <= FBG_RST;
      drv_r  <= DRV_RST;
      outg_r <= OUTG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLE: pole_r <= cfg_data[POLE_W-1:0];
        CFG_HALF: half_r <= cfg_data[HALF_W-1:0];
        CFG_FBG:  fbg_r  <= cfg_data[FBG_W-1:0];
        CFG_DRV:  drv_r  <= cfg_data[DRV_W-1:0];
        CFG_OUTG: outg_r <= cfg_data[OUTG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_FB: begin
        opx = {st3_r[SIG_W-1], st3_r};
        opy = {{(MULY_W-FBG_W){1'b0}}, fbg_r};
      end
      MUL_TANH: begin
        opx = {{(MULX_W-TANH_W-1){diff_r[TANH_W]}}, diff_r};
        opy = {{(MULY_W-TANH_SH){1'b0}}, frac_r};
      end
      MUL_STAGE: begin
        opx = sum_r;
        opy = {{(MULY_W-HALF_W){1'b0}}, half_r};
      end
      MUL_DRIVE: begin
        opx = {st3_r[SIG_W-1], st3_r};
        opy = {{(MULY_W-DRV_W){1'b0}}, drv_r};
      end
      MUL_OUT: begin
        opx = {{(MULX_W-TANH_W){t_r[TANH_W-1]}}, t_r};
        opy = {{(MULY_W-OUTG_W){1'b0}}, outg_r};
      end
      default: begin
        opx = '0;
        opy = '0;
      end
    endcase
  end

  always_comb begin
    case (cmd.stage)
      2'd0: begin
        xp = fed_r;
        yp = st1_r;
      end
      2'd1: begin
        xp = st1_r;
        yp = st2_r;
      end
      default: begin
        xp = st2_r;
        yp = st3_r;
      end
    endcase
  end

  assign prod_a_nxt = PROD_W'(opx) * PROD_W'(opy);
  assign prod_b_nxt = PRDB_W'(pole_r) * PRDB_W'(yp);

  // Round to nearest, ties away from zero: add half, less one when negative
  assign rnd_c = prod_a_r + RND_C - PROD_W'(prod_a_r[PROD_W-1]);
  assign rnd_t = prod_a_r + RND_T - PROD_W'(prod_a_r[PROD_W-1]);
  assign rnd_a = acc_r + RND_A - ACC_W'(acc_r[ACC_W-1]);

  assign tmag = targ_r[TARG_W-1] ? (TARG_W'(0) - targ_r) : targ_r;

  assign idx = tabs_r[TANH_SH-1 -: TANH_AW];
  assign hi  = (idx == TANH_AW'(TANH_TABLE_DEPTH - 1)) ? TANH_ONE : TANH_TAB[idx + 1'b1];

  assign v_sum = {1'b0, lo_r} + rnd_t[TANH_SH +: TANH_W+1];
  assign tpos  = tbig_r ? TANH_ONE : v_sum[TANH_W-1:0];
  assign t_nxt = tneg_r ? (TANH_W'(0) - tpos) : tpos;

  assign fdiff = {x_r[SIG_W-1], x_r} - {{(MULX_W-TANH_W){t_r[TANH_W-1]}}, t_r};
  assign f_nxt = sat_sig({{(33-MULX_W){fdiff[MULX_W-1]}}, fdiff});

  assign acc_nxt = prod_a_r[ACC_W-1:0] - {{(ACC_W-PRDB_W){prod_b_r[PRDB_W-1]}}, prod_b_r};
  assign y_nxt   = sat_sig({{(33-ACC_W+COEF_FRAC){rnd_a[ACC_W-1]}}, rnd_a[ACC_W-1:COEF_FRAC]});
  assign out_nxt = sat_sig(rnd_c[PROD_W-1:COEF_FRAC]);

  // Filter state: each stage commits its input slot once its sum has been formed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fed_r <= '0;
      st1_r <= '0;
      st2_r <= '0;
      st3_r <= '0;
    end else if (cmd.ld_stage) begin
      case (cmd.stage)
        2'd0: fed_r <= cur_r;
        2'd1: st1_r <= cur_r;
        default: begin
          st2_r <= cur_r;
          st3_r <= y_nxt;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_x) begin
      x_r <= in_sample_in;
    end
    if (cmd.mul_en) begin
      prod_a_r <= prod_a_nxt;
      prod_b_r <= prod_b_nxt;
    end
    if (cmd.ld_targ) begin
      targ_r <= rnd_c[PROD_W-1:COEF_FRAC];
    end
    if (cmd.ld_abs) begin
      tneg_r <= targ_r[TARG_W-1];
      tbig_r <= (tmag >= T_LIM);
      tabs_r <= tmag[TANH_SH-1:0];
    end
    if (cmd.ld_lut) begin
      lo_r   <= TANH_TAB[idx];
      diff_r <= {1'b0, hi} - {1'b0, TANH_TAB[idx]};
      frac_r <= {tabs_r[TANH_SH-1-TANH_AW:0], {TANH_AW{1'b0}}};
    end
    if (cmd.ld_t) begin
      t_r <= t_nxt;
    end
    if (cmd.ld_f) begin
      cur_r <= f_nxt;
    end else if (cmd.ld_stage) begin
      cur_r <= y_nxt;
    end
    if (cmd.ld_sum) begin
      sum_r <= {cur_r[SIG_W-1], cur_r} + {xp[SIG_W-1], xp};
    end
    if (cmd.ld_acc) begin
      acc_r <= acc_nxt;
    end
    if (cmd.ld_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_sample_out = out_r;

endmodule

`default_nettype wire

>>> design/tspl_ctrl.sv
// Controller: sequences one sample through the datapath and owns the handshakes.
`default_nettype none

module tspl_ctrl import tspl_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  output tspl_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FB_MUL  = 4'd1;
  localparam logic [3:0] S_TARG    = 4'd2;
  localparam logic [3:0] S_T_ABS   = 4'd3;
  localparam logic [3:0] S_T_LUT   = 4'd4;
  localparam logic [3:0] S_T_MUL   = 4'd5;
  localparam logic [3:0] S_T_FIN   = 4'd6;
  localparam logic [3:0] S_F_SUB   = 4'd7;
  localparam logic [3:0] S_SP_PREP = 4'd8;
  localparam logic [3:0] S_SP_MUL  = 4'd9;
  localparam logic [3:0] S_SP_ACC  = 4'd10;
  localparam logic [3:0] S_SP_FIN  = 4'd11;
  localparam logic [3:0] S_D_MUL   = 4'd12;
  localparam logic [3:0] S_O_MUL   = 4'd13;
  localparam logic [3:0] S_O_FIN   = 4'd14;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic [1:0] stage_r;
  logic [1:0] stage_nxt;
  logic       out_side_r;
  logic       out_side_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    stage_nxt    = stage_r;
    out_side_nxt = out_side_r;
    cmd          = '0;
    cmd.mul_sel  = MUL_FB;
    cmd.stage    = stage_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_x     = 1'b1;
          stage_nxt    = 2'd0;
          out_side_nxt = 1'b0;
          state_nxt    = S_FB_MUL;
        end
      end
      S_FB_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FB;
        state_nxt   = S_TARG;
      end
      S_TARG: begin
        cmd.ld_targ = 1'b1;
        state_nxt   = S_T_ABS;
      end
      S_T_ABS: begin
        cmd.ld_abs = 1'b1;
        state_nxt  = S_T_LUT;
      end
      S_T_LUT: begin
        cmd.ld_lut = 1'b1;
        state_nxt  = S_T_MUL;
      end
      S_T_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TANH;
        state_nxt   = S_T_FIN;
      end
      S_T_FIN: begin
        cmd.ld_t  = 1'b1;
        state_nxt = out_side_r ? S_O_MUL : S_F_SUB;
      end
      S_F_SUB: begin
        cmd.ld_f  = 1'b1;
        state_nxt = S_SP_PREP;
      end
      S_SP_PREP: begin
        cmd.ld_sum = 1'b1;
        state_nxt  = S_SP_MUL;
      end
      S_SP_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_STAGE;
        state_nxt   = S_SP_ACC;
      end
      S_SP_ACC: begin
        cmd.ld_acc = 1'b1;
        state_nxt  = S_SP_FIN;
      end
      S_SP_FIN: begin
        cmd.ld_stage = 1'b1;
        if (stage_r == 2'd2) begin
          state_nxt = S_D_MUL;
        end else begin
          stage_nxt = stage_r + 2'd1;
          state_nxt = S_SP_PREP;
        end
      end
      S_D_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_DRIVE;
        out_side_nxt = 1'b1;
        state_nxt    = S_TARG;
      end
      S_O_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_OUT;
        state_nxt   = S_O_FIN;
      end
      S_O_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stage_r     <= 2'd0;
      out_side_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      out_side_r  <= out_side_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_FB_MUL && !out_side_r && stage_r == 2'd0))
    else $error("accepted beat did not start the feedback pass");

  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r != 2'd3)
    else $error("stage counter out of range");

  a_drive_after_third: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_D_MUL) |-> (stage_r == 2'd2 && !out_side_r))
    else $error("output pass entered before the third section");

  a_tanh_return: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_F_SUB) |-> !out_side_r) and ((state_r == S_O_MUL) |-> out_side_r))
    else $error("tanh pass returned to the wrong caller");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |=> (out_valid_r && state_r == S_IDLE))
    else $error("result beat not presented after load");

endmodule

`default_nettype wire

>>> design/three_pole_saturating_lowpass.sv
// Top level: three-pole saturating lowpass with tanh resonance feedback.
// An accepted sample runs through the whole controller sequence before out_valid
// rises, later still while the previous result waits in the output register.
// A new sample is taken only after the previous one has run its dependent chain
// of eight multiply, round and saturate steps on the shared multiplier pair.
// Reset (rst_n low, synchronous) clears the filter state and loads the default
// coefficients; the tanh table is a constant and needs no fill.
`default_nettype none

module three_pole_saturating_lowpass import tspl_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [SIG_W-1:0]  in_sample_in,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [SIG_W-1:0]       out_sample_out
);

  tspl_cmd_t cmd;

  tspl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tspl_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_sample_in   (in_sample_in),
    .cmd            (cmd),
    .out_sample_out (out_sample_out)
  );

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking testbench for the three-pole saturating lowpass: directed table, random phases.
`timescale 1ns / 100ps

module tb_top import tspl_pkg::*;;

  localparam int     PHASES        = 10;
  localparam int     PHASE_ITEMS   = 53;
  localparam int     CALM_PHASE    = 4;
  localparam int     HOLD_AT_ITEM  = 380;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     IDLE_PCT      = 6;
  localparam int     MAX_PRINTS    = 100;
  localparam longint SIG_HI        = 8388607;
  localparam longint SIG_LO        = -8388608;
  localparam longint AUDIO_AMP     = 262144;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;

  typedef enum logic {ROW_REG, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_W-1:0]         data;
    logic signed [SIG_W-1:0]  smp;
    bit                       typed;
    logic signed [SIG_W-1:0]  want;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [SIG_W-1:0]  in_sample_in = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [SIG_W-1:0]  out_sample_out;

  // filter state and coefficients as the block should hold them
  longint tanh_lut [TANH_TABLE_DEPTH];
  longint pole_k, half_k, fbg_k, drv_k, outg_k;
  longint fed_x, st1, st2, st3;

  logic signed [SIG_W-1:0] filtered_due [$];
  stim_row_t               script [$];
  int                      mismatches = 0;
  int                      taken_in = 0;
  bit                      calm = 1'b0;
  int                      hold_left = 0;
  bit                      hold_done = 1'b0;

  three_pole_saturating_lowpass dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // divide by 2^s, round half away from zero
  function automatic longint round_shift(input longint v, input int s);
    longint mag;
    longint r;
    mag = (v < 0) ? -v : v;
    r   = (mag + (longint'(1) <<< (s - 1))) >>> s;
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint clamp_sig(input longint v);
    if (v > SIG_HI) begin
      return SIG_HI;
    end else if (v < SIG_LO) begin
      return SIG_LO;
    end
    return v;
  endfunction

  function automatic longint soft_clip(input longint x);
    longint one;
    longint m;
    longint p;
    longint idx;
    longint frac;
    longint lo;
    longint hi;
    longint v;
    one = longint'(1) <<< SAMPLE_FRAC_BITS;
    m   = (x < 0) ? -x : x;
    if (m >= (longint'(8) <<< SAMPLE_FRAC_BITS)) begin
      v = one;
    end else begin
      p    = m * TANH_TABLE_DEPTH;
      idx  = p >>> TANH_SH;
      frac = p & ((longint'(1) <<< TANH_SH) - 1);
      if (idx >= TANH_TABLE_DEPTH) begin
        idx = TANH_TABLE_DEPTH - 1;
      end
      lo = tanh_lut[idx];
      hi = (idx + 1 < TANH_TABLE_DEPTH) ? tanh_lut[idx + 1] : one;
      v  = lo + round_shift((hi - lo) * frac, TANH_SH);
    end
    return (x < 0) ? -v : v;
  endfunction

  function automatic longint pole_section(input longint xn, input longint xp, input longint yp);
    return clamp_sig(round_shift(half_k * (xn + xp) - pole_k * yp, COEF_FRAC));
  endfunction

  // advance the filter by one sample and return the output sample
  function automatic longint ladder_advance(input longint x);
    longint f;
    longint s1;
    longint s2;
    longint s3;
    f     = clamp_sig(x - soft_clip(round_shift(fbg_k * st3, COEF_FRAC)));
    s1    = pole_section(f, fed_x, st1);
    s2    = pole_section(s1, st1, st2);
    s3    = pole_section(s2, st2, st3);
    fed_x = f;
    st1   = s1;
    st2   = s2;
    st3   = s3;
    return clamp_sig(round_shift(outg_k * soft_clip(round_shift(drv_k * s3, COEF_FRAC)),
                                 COEF_FRAC));
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  function automatic void put_reg(input logic [CFG_IDX_W-1:0] idx, input longint v);
    stim_row_t row;
    row      = '{ROW_REG, idx, CFG_W'(v), '0, 1'b0, '0};
    script   = {script, row};
  endfunction

  function automatic void put_sample(input longint x, input bit typed, input longint want);
    stim_row_t row;
    row      = '{ROW_SAMPLE, '0, '0, SIG_W'(x), typed, SIG_W'(want)};
    script   = {script, row};
  endfunction

  function automatic logic [CFG_W-1:0] pick_setting(input longint lo, input longint hi,
                                                    input longint usual, input bit plain);
    if (plain) begin
      return CFG_W'(usual);
    end
    case ($urandom_range(0, 9))
      0:       return CFG_W'(lo);
      1:       return CFG_W'(hi);
      2:       return CFG_W'($urandom);
      default: return CFG_W'(usual);
    endcase
  endfunction

  // write only with nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    in_valid <= 1'b0;
    while (filtered_due.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POLE: pole_k = longint'($signed(data[POLE_W-1:0]));
      CFG_HALF: half_k = longint'(data[HALF_W-1:0]);
      CFG_FBG:  fbg_k  = longint'(data[FBG_W-1:0]);
      CFG_DRV:  drv_k  = longint'(data[DRV_W-1:0]);
      CFG_OUTG: outg_k = longint'(data[OUTG_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [SIG_W-1:0] x, input bit typed,
                             input logic signed [SIG_W-1:0] want);
    longint                  y;
    logic signed [SIG_W-1:0] due;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    y            = ladder_advance(longint'(x));
    due          = typed ? want : SIG_W'(y);
    filtered_due = {filtered_due, due};
    taken_in++;
  endtask

  // receiver: check each beat taken, then decide the stall for the next edge
  always @(posedge clk) begin : sink
    logic signed [SIG_W-1:0] due_head;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (filtered_due.size() == 0) begin
          flag_mismatch($sformatf("sample_out %0d with nothing pending", out_sample_out));
        end else begin
          due_head = filtered_due.pop_front();
          if (out_sample_out !== due_head) begin
            flag_mismatch($sformatf("sample_out %0d, want %0d", out_sample_out, due_head));
          end
        end
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && taken_in >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin : run
    longint unsigned        h;
    longint unsigned        term;
    longint unsigned        r;
    longint unsigned        e;
    longint unsigned        den;
    longint unsigned        num;
    longint                 usual_pole;
    logic signed [SIG_W-1:0] x;
    int                     n;
    int                     k;
    int                     ph;
    int                     i;

    // tanh(8k/depth) via e = r^k, r a Q.32 series for exp(-16/depth)
    h    = (64'd16 << 32) / TANH_TABLE_DEPTH;
    term = 64'd1 << 32;
    r    = 64'd1 << 32;
    e    = 64'd1 << 32;
    for (n = 1; n < 25; n++) begin
      term = ((term * h + 64'h8000_0000) >> 32) / n;
      if (n % 2 == 1) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    for (k = 0; k < TANH_TABLE_DEPTH; k++) begin
      den         = (64'd1 << 32) + e;
      num         = ((64'd1 << 32) - e) << SAMPLE_FRAC_BITS;
      tanh_lut[k] = longint'((num + den / 2) / den);
      e           = (e * r + 64'h8000_0000) >> 32;
    end

    pole_k = -65431;
    half_k = 52;
    fbg_k  = 0;
    drv_k  = 65536;
    outg_k = 196608;
    fed_x  = 0;
    st1    = 0;
    st2    = 0;
    st3    = 0;

    // silence in, silence out from reset
    put_sample(0, 1'b1, 0);
    // unity sections, hard drive: full scale saturates to the output gain
    put_reg(CFG_POLE, 0);
    put_reg(CFG_HALF, 65536);
    put_reg(CFG_FBG, 0);
    put_reg(CFG_DRV, 8388607);
    put_reg(CFG_OUTG, 262144);
    put_sample(SIG_HI, 1'b1, 262144);
    put_sample(SIG_LO, 1'b0, 0);
    put_sample(SIG_LO, 1'b0, 0);
    put_sample(SIG_HI, 1'b0, 0);
    // zero volume mutes everything
    put_reg(CFG_OUTG, 0);
    put_sample(12345, 1'b1, 0);
    // growing poles drive every stage into saturation
    put_reg(CFG_OUTG, 262144);
    put_reg(CFG_DRV, 65536);
    put_reg(CFG_HALF, 131072);
    put_reg(CFG_POLE, -131072);
    put_sample(SIG_HI, 1'b0, 0);
    put_sample(1, 1'b0, 0);
    put_sample(-1, 1'b0, 0);
    put_sample(0, 1'b0, 0);
    put_sample(SIG_LO, 1'b0, 0);
    put_reg(CFG_POLE, 131071);
    put_reg(CFG_HALF, 0);
    put_sample(SIG_HI, 1'b0, 0);
    put_sample(-65536, 1'b0, 0);
    put_sample(0, 1'b0, 0);
    // heavy resonance
    put_reg(CFG_FBG, 1048576);
    put_reg(CFG_HALF, 32768);
    put_reg(CFG_POLE, -32768);
    put_sample(4194304, 1'b0, 0);
    put_sample(-4194304, 1'b0, 0);
    put_sample(65536, 1'b0, 0);
    put_sample(0, 1'b0, 0);
    // writes to unused indexes must change nothing
    put_reg(CFG_UNUSED_A, 8388607);
    put_reg(CFG_UNUSED_B, 0);
    put_sample(100, 1'b0, 0);
    // all ones in every register, bits above each width dropped
    put_reg(CFG_POLE, 8388607);
    put_reg(CFG_HALF, 8388607);
    put_reg(CFG_FBG, 8388607);
    put_reg(CFG_DRV, 8388607);
    put_reg(CFG_OUTG, 8388607);
    put_sample(-1, 1'b0, 0);
    put_sample(SIG_HI, 1'b0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[j]) begin
      if (script[j].kind == ROW_REG) begin
        write_reg(script[j].idx, script[j].data);
      end else begin
        send_sample(script[j].smp, script[j].typed, script[j].want);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      calm <= (ph == CALM_PHASE);
      usual_pole = -longint'($urandom_range(0, 65535));
      write_reg(CFG_POLE, pick_setting(-131072, 131071, usual_pole, ph < 2));
      write_reg(CFG_HALF, pick_setting(0, 131072, (usual_pole + 65536) / 2, ph < 2));
      write_reg(CFG_FBG, pick_setting(0, 1048576, $urandom_range(0, 1048576), ph < 2));
      write_reg(CFG_DRV, pick_setting(65536, 8388607, $urandom_range(65536, 1048576), ph < 2));
      write_reg(CFG_OUTG, pick_setting(0, 262144, $urandom_range(0, 262144), ph < 2));
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B, CFG_W'($urandom));
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: x = SIG_W'($urandom);
          4, 5, 6:    x = SIG_W'(longint'($urandom_range(0, 2 * AUDIO_AMP)) - AUDIO_AMP);
          7:          x = $urandom_range(0, 1) ? SIG_W'(SIG_HI) : SIG_W'(SIG_LO);
          default:    x = (i & 8) ? SIG_W'(196608) : SIG_W'(-196608);
        endcase
        send_sample(x, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    calm     <= 1'b0;
    while (filtered_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
